[rtl/core/kti_pkg.sv]
// ----------------------------------------------------------------------------
// kti_pkg
// Shared types and constants for the keyframe track interpolator.
// ----------------------------------------------------------------------------
package kti_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned TOL_W  = 16;
    localparam int unsigned CNT_W  = 6;
    localparam int unsigned FRAC_W = 16;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [1:0] t_status;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    localparam logic OP_EVAL = 1'b0;
    localparam logic OP_SET  = 1'b1;

    typedef struct packed {
        t_word t;
        t_word x;
        t_word y;
        t_word z;
        t_word w;
    } t_key;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic  shift;     // each cell above pos takes its left neighbour
        logic  write;     // cell at pos takes the new key
        logic  wr_time;   // also load the time (insert)
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DIV,
        S_MUL,
        S_DONE
    } t_state;

endpackage

[rtl/core/kti_cell.sv]
// ----------------------------------------------------------------------------
// kti_cell
// One slot of the key table; shifts in its left neighbour on insert.
// ----------------------------------------------------------------------------
module kti_cell #(
    parameter int unsigned IDX_W = 5,
    parameter int unsigned MY_IDX = 0
) (
    input  logic               i_clk,
    input  kti_pkg::t_cell_ctl i_ctl,
    input  logic [IDX_W-1:0]   i_pos,
    input  kti_pkg::t_key      i_left,
    input  kti_pkg::t_key      i_new,
    output kti_pkg::t_key      o_key
);
    import kti_pkg::*;

    t_key r_key;
    localparam logic [IDX_W-1:0] ME = IDX_W'(MY_IDX);

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift && (ME > i_pos)) begin
            r_key <= i_left;
        end else if (i_ctl.write && (ME == i_pos)) begin
            if (i_ctl.wr_time) begin
                r_key.t <= i_new.t;
            end
            r_key.x <= i_new.x;
            r_key.y <= i_new.y;
            r_key.z <= i_new.z;
            r_key.w <= i_new.w;
        end
    end

    assign o_key = r_key;
endmodule

[rtl/core/kti_div.sv]
// ----------------------------------------------------------------------------
// kti_div
// Restoring divider, one quotient bit per cycle, 16-bit fraction.
// ----------------------------------------------------------------------------
module kti_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [32:0]           i_num,
    input  logic [32:0]           i_den,
    output logic                  o_done,
    output logic [15:0]           o_quot
);
    import kti_pkg::*;

    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [15:0] r_q;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [33:0] n_trial;

    // num < den, so each step doubles the remainder and subtracts
    assign n_trial = {r_rem[32:0], 1'b0} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd15) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            if (!n_trial[33]) begin
                r_rem <= n_trial;
                r_q   <= {r_q[14:0], 1'b1};
            end else begin
                r_rem <= {r_rem[32:0], 1'b0};
                r_q   <= {r_q[14:0], 1'b0};
            end
        end
    end

    assign o_done = r_busy && (r_cnt == 5'd15);
    assign o_quot = n_trial[33] ? {r_q[14:0], 1'b0} : {r_q[14:0], 1'b1};
endmodule

[rtl/core/keyframe_track_interpolator.sv]
// ----------------------------------------------------------------------------
// keyframe_track_interpolator
// Sorted keyframe table in a chain of cells, with clamp and linear blend.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  input     in    i_valid / o_ready    i_op, i_time_req, i_val_x..w
//  result    out   o_valid / i_ready    o_status, o_out_x..w, o_key_count
//  config    in    i_cfg_valid/o_cfg_ready  i_cfg_data (match tolerance)
//
// A set or a clamped evaluate scans the n keys held (up to MAX_KEYS), one
// slot scanned per cycle, then passes through a decide and a done state.
// An interpolated evaluate adds the bit-serial divider and a multiply
// state between decide and done.
// Reset clears the key count and control; the table itself is not cleared.
// A new request is taken once the previous result has been handed over.
module keyframe_track_interpolator #(
    parameter int unsigned MAX_KEYS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_op,
    input  logic signed [31:0]      i_time_req,
    input  logic signed [31:0]      i_val_x,
    input  logic signed [31:0]      i_val_y,
    input  logic signed [31:0]      i_val_z,
    input  logic signed [31:0]      i_val_w,
    output logic                    o_valid,
    input  logic                    i_ready,
    output kti_pkg::t_status        o_status,
    output logic signed [31:0]      o_out_x,
    output logic signed [31:0]      o_out_y,
    output logic signed [31:0]      o_out_z,
    output logic signed [31:0]      o_out_w,
    output logic [5:0]              o_key_count,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [15:0]             i_cfg_data
);
    import kti_pkg::*;

    localparam int unsigned IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int unsigned N_W   = $clog2(MAX_KEYS + 1);

    t_state r_state, n_state;
    logic [15:0]      r_tol;
    logic [N_W-1:0]   r_used;
    logic [IDX_W-1:0] r_ptr;      // scan pointer
    logic             r_op;
    t_key             r_req;
    // scan results
    logic             r_found;
    logic [32:0]      r_best_d;
    logic [IDX_W-1:0] r_best;
    logic [IDX_W-1:0] r_ins;      // first slot with time > t
    logic             r_ins_hit;
    logic             r_brk_hit;  // some slot (>=1) has time >= t
    // evaluate data
    t_key             r_a, r_b;
    logic [15:0]      r_frac;
    // result
    logic             r_ovalid;
    t_status          r_ostat;
    t_word            r_ox, r_oy, r_oz, r_ow;

    t_key             w_key [MAX_KEYS];
    t_key             w_cur;
    t_cell_ctl        w_ctl;
    logic [IDX_W-1:0] w_pos;

    // ---------------- cell chain ----------------
    genvar g;
    generate
        for (g = 0; g < MAX_KEYS; g++) begin : g_cell
            t_key w_left;
            if (g == 0) begin : g_first
                assign w_left = r_req;
            end else begin : g_rest
                assign w_left = w_key[g-1];
            end
            kti_cell #(.IDX_W(IDX_W), .MY_IDX(g)) u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_pos  (w_pos),
                .i_left (w_left),
                .i_new  (r_req),
                .o_key  (w_key[g])
            );
        end
    endgenerate

    assign w_cur = w_key[r_ptr];

    // ---------------- scan compare ----------------
    logic [32:0] w_diff, w_absd;
    logic        w_gt, w_ge;
    assign w_diff = {w_cur.t[31], w_cur.t} - {r_req.t[31], r_req.t};
    assign w_absd = w_diff[32] ? (33'd0 - w_diff) : w_diff;
    assign w_gt   = ($signed(w_cur.t) > $signed(r_req.t));
    assign w_ge   = ($signed(w_cur.t) >= $signed(r_req.t));

    logic w_last;
    assign w_last = (N_W'(r_ptr) + N_W'(1)) >= r_used;

    // ---------------- divider ----------------
    logic        w_div_start, w_div_done;
    logic [15:0] w_quot;
    logic [32:0] w_num, w_den;
    assign w_num = {r_req.t[31], r_req.t} - {r_a.t[31], r_a.t};
    assign w_den = {r_b.t[31], r_b.t} - {r_a.t[31], r_a.t};

    kti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    function automatic t_word lerp(input t_word a, input t_word b, input logic [15:0] f);
        logic signed [32:0] d;
        logic signed [49:0] p;
        begin
            d = {b[31], b} - {a[31], a};
            p = d * $signed({1'b0, f});
            lerp = t_word'(a + t_word'(p >>> 16));
        end
    endfunction

    // ---------------- control ----------------
    logic w_full;
    assign w_full = (r_used == N_W'(MAX_KEYS));

    always_comb begin
        n_state     = r_state;
        w_ctl       = '0;
        w_pos       = r_best;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_state = (r_used == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_op == OP_SET) begin
                    n_state = S_DONE;
                    if (r_found) begin
                        w_ctl.write = 1'b1;
                        w_pos = r_best;
                    end else if (!w_full) begin
                        w_pos = r_ins_hit ? r_ins : IDX_W'(r_used);
                        w_ctl.shift = 1'b1;
                        w_ctl.write = 1'b1;
                        w_ctl.wr_time = 1'b1;
                    end
                end else if (r_used == '0 || r_req.t <= r_a.t || r_req.t >= r_b.t ||
                             !r_brk_hit) begin
                    n_state = S_DONE;
                end else begin
                    w_div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready     = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tol    <= 16'd7;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_tol <= i_cfg_data;
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_DONE) begin
                r_ovalid <= 1'b1;
            end
            if (r_state == S_DECIDE && r_op == OP_SET && !r_found && !w_full) begin
                r_used <= r_used + N_W'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op      <= i_op;
                r_req     <= '{t: i_time_req, x: i_val_x, y: i_val_y,
                               z: i_val_z, w: i_val_w};
                r_ptr     <= '0;
                r_found   <= 1'b0;
                r_best_d  <= {17'd0, r_tol};
                r_best    <= '0;
                r_ins_hit <= 1'b0;
                r_ins     <= '0;
                r_brk_hit <= 1'b0;
            end
            S_SCAN: begin
                if (w_absd <= r_best_d) begin
                    r_best_d <= w_absd;
                    r_best   <= r_ptr;
                    r_found  <= 1'b1;
                end
                if (w_gt && !r_ins_hit) begin
                    r_ins_hit <= 1'b1;
                    r_ins     <= r_ptr;
                end
                if (r_ptr == '0) begin
                    r_a <= w_cur;
                end
                // bracket: first slot from 1 with time >= t; keep its left key
                if (r_ptr != '0 && w_ge && !r_brk_hit) begin
                    r_brk_hit <= 1'b1;
                    r_b       <= w_cur;
                    r_a       <= w_key[r_ptr - IDX_W'(1)];
                end
                if (!w_last) begin
                    r_ptr <= r_ptr + IDX_W'(1);
                end
            end
            S_DECIDE: begin
                r_ox <= '0; r_oy <= '0; r_oz <= '0; r_ow <= '0;
                r_ostat <= ST_OK;
                if (r_op == OP_SET) begin
                    if (!r_found && w_full) begin
                        r_ostat <= ST_FULL;
                    end
                end else if (r_used == '0) begin
                    r_ostat <= ST_EMPTY;
                end else if (r_req.t <= w_key[0].t) begin
                    r_ox <= w_key[0].x; r_oy <= w_key[0].y;
                    r_oz <= w_key[0].z; r_ow <= w_key[0].w;
                end else if (r_req.t >= w_key[r_ptr].t) begin
                    r_ox <= w_key[r_ptr].x; r_oy <= w_key[r_ptr].y;
                    r_oz <= w_key[r_ptr].z; r_ow <= w_key[r_ptr].w;
                end else if (r_brk_hit && r_req.t >= r_b.t) begin
                    r_ox <= r_b.x; r_oy <= r_b.y; r_oz <= r_b.z; r_ow <= r_b.w;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    r_frac <= w_quot;
                end
            end
            S_MUL: begin
                r_ox <= lerp(r_a.x, r_b.x, r_frac);
                r_oy <= lerp(r_a.y, r_b.y, r_frac);
                r_oz <= lerp(r_a.z, r_b.z, r_frac);
                r_ow <= lerp(r_a.w, r_b.w, r_frac);
            end
            default: ;
        endcase
    end

    assign o_valid     = r_ovalid;
    assign o_status    = r_ostat;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_out_z     = r_oz;
    assign o_out_w     = r_ow;
    assign o_key_count = CNT_W'(r_used);

    // ---------------- checks ----------------
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= N_W'(MAX_KEYS)) else $error("key count above table size");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("request taken while busy");
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != $past(r_used)) |-> (r_used == $past(r_used) + N_W'(1)))
        else $error("key count moved by more than one");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> r_ovalid) else $error("result lost");
endmodule
